// ===== hdl/rtcp_rb_pkg.sv =====
// Package for the RTCP report builder: request codes, RTCP constants,
// item, frame and state types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtcp_rb_pkg;

  typedef enum logic [1:0] {
    REQ_SR   = 2'd0,
    REQ_RR   = 2'd1,
    REQ_RB   = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  localparam int unsigned MaxWords = 7;
  localparam int unsigned CntW     = 3;

  localparam logic [1:0]  RtcpVersion = 2'd2;
  localparam logic [7:0]  PtSr        = 8'd200;
  localparam logic [7:0]  PtRr        = 8'd201;
  localparam logic [7:0]  SrWords     = 8'd7;
  localparam logic [7:0]  RrWords     = 8'd2;
  localparam logic [7:0]  RbWords     = 8'd6;
  localparam logic [11:0] CapReset    = 12'd1500;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] ssrc;
    logic [63:0] ntp_time;
    logic [31:0] rtp_time;
    logic [31:0] sender_pkts;
    logic [31:0] octet_count;
    logic [4:0]  report_count;
    logic [7:0]  loss_fraction;
    logic [23:0] lost_total;
    logic [31:0] highest_sequence;
    logic [31:0] arrival_jitter;
    logic [63:0] sr_timing;
  } item_t;

  typedef struct packed {
    logic [MaxWords-1:0][31:0] words;
    logic [CntW-1:0]           cnt;
    logic                      last;
    logic                      err;
  } frame_t;

  typedef struct packed {
    logic [4:0] blocks_left;
    logic       dropping;
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/rtcp_report_builder.sv =====
// RTCP SR/RR report builder: first word of a transaction is shown in the cycle
// after acceptance, then one word per cycle from the output word buffer while
// out_ready_i is high. An SR header yields 7 words, RR header 2, report block 6;
// the next item is taken as the last word leaves.
// Reset: capacity 1500 bytes, no open packet, buffer empty.
// Depends on rtcp_rb_pkg, rtcp_rb_builder, rtcp_rb_outbuf.
`timescale 1ns / 1ps
`default_nettype none
module rtcp_report_builder
  import rtcp_rb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] ssrc_i,
  input  logic [63:0] ntp_time_i,
  input  logic [31:0] rtp_time_i,
  input  logic [31:0] sender_pkts_i,
  input  logic [31:0] octet_count_i,
  input  logic [4:0]  report_count_i,
  input  logic [7:0]  loss_fraction_i,
  input  logic [23:0] lost_total_i,
  input  logic [31:0] highest_sequence_i,
  input  logic [31:0] arrival_jitter_i,
  input  logic [63:0] sr_timing_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] packet_word_o,
  output logic        end_of_packet_o,
  output logic        overflow_error_o
);

  logic [11:0] cap_q;
  state_t      st_q, st_d;
  item_t       item;
  frame_t      frame;
  logic        accept;

  assign item = '{
    req_type:         req_type_i,
    ssrc:             ssrc_i,
    ntp_time:         ntp_time_i,
    rtp_time:         rtp_time_i,
    sender_pkts:      sender_pkts_i,
    octet_count:      octet_count_i,
    report_count:     report_count_i,
    loss_fraction:    loss_fraction_i,
    lost_total:       lost_total_i,
    highest_sequence: highest_sequence_i,
    arrival_jitter:   arrival_jitter_i,
    sr_timing:        sr_timing_i
  };

  assign accept = in_valid_i && in_ready_o;

  rtcp_rb_builder u_builder (
    .item_i  (item),
    .st_i    (st_q),
    .cap_i   (cap_q),
    .frame_o (frame),
    .st_o    (st_d)
  );

  rtcp_rb_outbuf u_outbuf (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept),
    .frame_i          (frame),
    .can_load_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .packet_word_o    (packet_word_o),
    .end_of_packet_o  (end_of_packet_o),
    .overflow_error_o (overflow_error_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
      st_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        st_q <= st_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_is_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_error_o |-> end_of_packet_o && (packet_word_o == 32'd0))
    else $error("refusal result must be a single zero end word");

  a_sr_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == REQ_SR) && !st_d.dropping
    |=> out_valid_o && (packet_word_o[23:16] == PtSr) && !overflow_error_o)
    else $error("accepted sender report did not present its header");

  a_block_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == REQ_RB) && (st_q.blocks_left != 5'd0)
    |=> st_q.blocks_left == $past(st_q.blocks_left) - 5'd1)
    else $error("report block did not consume one expected block");

  a_orphan_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == REQ_RB) && (st_q.blocks_left == 5'd0) |=> !out_valid_o)
    else $error("block without open packet produced output");
`endif

endmodule
`default_nettype wire

// ===== hdl/rtcp_rb_builder.sv =====
// Builds the words of one transaction and the next packet state.
// Depends on rtcp_rb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtcp_rb_builder
  import rtcp_rb_pkg::*;
(
  input  item_t       item_i,
  input  state_t      st_i,
  input  logic [11:0] cap_i,
  output frame_t      frame_o,
  output state_t      st_o
);

  logic        is_sr;
  logic [7:0]  words;
  logic [9:0]  bytes;
  logic        too_big;
  logic [31:0] hdr;
  logic [4:0]  left_dec;

  assign is_sr   = (req_e'(item_i.req_type) == REQ_SR);
  assign words   = (is_sr ? SrWords : RrWords) + RbWords * {3'b000, item_i.report_count};
  assign bytes   = {words, 2'b00};
  assign too_big = {2'b00, bytes} > cap_i;
  assign hdr     = {RtcpVersion, 1'b0, item_i.report_count, (is_sr ? PtSr : PtRr),
                    8'h00, words - 8'd1};
  assign left_dec = st_i.blocks_left - 5'd1;

  always_comb begin
    frame_o = '0;
    st_o    = st_i;
    unique case (req_e'(item_i.req_type))
      REQ_SR, REQ_RR: begin
        st_o.blocks_left = item_i.report_count;
        st_o.dropping    = too_big;
        if (too_big) begin
          frame_o.cnt  = CntW'(1);
          frame_o.last = 1'b1;
          frame_o.err  = 1'b1;
        end else begin
          frame_o.last     = (item_i.report_count == 5'd0);
          frame_o.words[0] = hdr;
          frame_o.words[1] = item_i.ssrc;
          if (is_sr) begin
            frame_o.words[2] = item_i.ntp_time[63:32];
            frame_o.words[3] = item_i.ntp_time[31:0];
            frame_o.words[4] = item_i.rtp_time;
            frame_o.words[5] = item_i.sender_pkts;
            frame_o.words[6] = item_i.octet_count;
            frame_o.cnt      = CntW'(SrWords);
          end else begin
            frame_o.cnt      = CntW'(RrWords);
          end
        end
      end
      REQ_RB: begin
        if (st_i.blocks_left != 5'd0) begin
          st_o.blocks_left = left_dec;
          if (!st_i.dropping) begin
            frame_o.words[0] = item_i.ssrc;
            frame_o.words[1] = {item_i.loss_fraction, item_i.lost_total};
            frame_o.words[2] = item_i.highest_sequence;
            frame_o.words[3] = item_i.arrival_jitter;
            frame_o.words[4] = item_i.sr_timing[63:32];
            frame_o.words[5] = item_i.sr_timing[31:0];
            frame_o.cnt      = CntW'(RbWords);
            frame_o.last     = (left_dec == 5'd0);
          end
        end
      end
      REQ_NONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/rtcp_rb_outbuf.sv =====
// Word buffer that holds one transaction's frame and shifts it out one
// word per cycle while out_ready_i is high. Depends on rtcp_rb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtcp_rb_outbuf
  import rtcp_rb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  frame_t      frame_i,
  output logic        can_load_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] packet_word_o,
  output logic        end_of_packet_o,
  output logic        overflow_error_o
);

  logic [MaxWords-1:0][31:0] words_q, words_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      last_q, last_d;
  logic                      err_q, err_d;
  logic                      pop;

  assign out_valid_o      = (cnt_q != '0);
  assign pop              = out_valid_o && out_ready_i;
  assign can_load_o       = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign packet_word_o    = words_q[0];
  assign end_of_packet_o  = (cnt_q == CntW'(1)) && last_q;
  assign overflow_error_o = err_q;

  always_comb begin
    words_d = words_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    err_d   = err_q;
    priority if (load_i) begin
      words_d = frame_i.words;
      cnt_d   = frame_i.cnt;
      last_d  = frame_i.last;
      err_d   = frame_i.err;
    end else if (pop) begin
      for (int i = 0; i < MaxWords - 1; i++) begin
        words_d[i] = words_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

endmodule
`default_nettype wire
